FILE: sv/bba_pkg.sv
// Shared types, codes and defaults for the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int unsigned DEF_BLOCK_COUNT     = 4096;
  localparam int unsigned DEF_RESERVED_BLOCKS = 514;
  localparam int unsigned DEF_MAP_WORD_BITS   = 64;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic clear;
    logic load;
    logic prep;
    logic run;
    logic eval;
    logic finish;
  } bba_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic eval_done;
    logic out_free;
  } bba_stat_t;

endpackage

`default_nettype wire

FILE: sv/bitmap_block_allocator_core.sv
// Top level of the bitmap block allocator with its stream ports.
`timescale 1ns / 1ps
`default_nettype none

// The allocator keeps one used bit per block in an on-chip map of
// MAP_WORD_BITS-bit words and serves one request at a time. After reset it
// runs a clearing pass of one map word per cycle that marks the reserved low
// blocks used, and holds in_tready low until that pass ends. An allocate
// request reads the map one word per cycle from the first word that holds a
// non-reserved block. The next request is taken as soon as the result is in
// the output register, even while it waits there.

module bitmap_block_allocator_core
  import bba_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT     = DEF_BLOCK_COUNT,
  parameter int unsigned RESERVED_BLOCKS = DEF_RESERVED_BLOCKS,
  parameter int unsigned MAP_WORD_BITS   = DEF_MAP_WORD_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] block_index, [15:12] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [11:0] result_index, [12] used, [15:13] zero
  output logic [1:0]       out_tuser   // [1:0] status
);

  bba_cmd_t            cmd;
  bba_stat_t           stat;
  logic [INDEX_W-1:0]  result_index;
  logic                used;
  logic [STATUS_W-1:0] status;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bba_datapath #(
    .BLOCK_COUNT     (BLOCK_COUNT),
    .RESERVED_BLOCKS (RESERVED_BLOCKS),
    .MAP_WORD_BITS   (MAP_WORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (in_tuser),
    .in_block_index   (in_tdata[INDEX_W-1:0]),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_status       (status),
    .out_result_index (result_index),
    .out_used         (used)
  );

  assign out_tdata = {3'b000, used, result_index};
  assign out_tuser = status;

endmodule

`default_nettype wire

FILE: sv/bba_ctrl.sv
// Sequencer that steps the allocator datapath through clearing and each request.
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire bba_stat_t stat,
  output bba_cmd_t       cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        cmd.run   = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.run  = 1'b1;
        cmd.eval = 1'b1;
        if (stat.eval_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bba_datapath.sv
// Usage map memory, word scan, index decode and result registers of the allocator.
`timescale 1ns / 1ps
`default_nettype none

module bba_datapath
  import bba_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT     = DEF_BLOCK_COUNT,
  parameter int unsigned RESERVED_BLOCKS = DEF_RESERVED_BLOCKS,
  parameter int unsigned MAP_WORD_BITS   = DEF_MAP_WORD_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bba_cmd_t            cmd,
  output bba_stat_t                stat,
  input  wire logic [REQ_W-1:0]    in_req_type,
  input  wire logic [INDEX_W-1:0]  in_block_index,
  input  wire logic                out_tready,
  output logic                     out_tvalid,
  output logic [STATUS_W-1:0]      out_status,
  output logic [INDEX_W-1:0]       out_result_index,
  output logic                     out_used
);

  localparam int unsigned WB        = MAP_WORD_BITS;
  localparam int unsigned MAP_WORDS = (BLOCK_COUNT + WB - 1) / WB;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW        = $clog2(BLOCK_COUNT);
  localparam int unsigned BBW       = $clog2(WB);
  localparam int unsigned LAST_WORD = MAP_WORDS - 1;
  localparam int unsigned LAST_BITS = BLOCK_COUNT - LAST_WORD * WB;
  localparam bit          ALLOC_NONE = (RESERVED_BLOCKS >= BLOCK_COUNT);
  localparam int unsigned START_WORD = ALLOC_NONE ? 0 : RESERVED_BLOCKS / WB;
  localparam int unsigned START_BIT  = ALLOC_NONE ? 0 : RESERVED_BLOCKS % WB;
  localparam int unsigned START_BASE = START_WORD * WB;
  localparam int unsigned RES_EFF    = ALLOC_NONE ? BLOCK_COUNT : RESERVED_BLOCKS;
  localparam int unsigned FULL_WORDS = RES_EFF / WB;
  localparam int unsigned PART_BITS  = RES_EFF % WB;
  localparam int unsigned RECIP_SH   = INDEX_W + 7;
  localparam int unsigned RECIP      = ((1 << RECIP_SH) + WB - 1) / WB;
  localparam int unsigned PROD_W     = 32;

  logic [WB-1:0] mem [MAP_WORDS];

  logic [REQ_W-1:0]    req_r;
  logic [INDEX_W-1:0]  idx_r;
  logic [INDEX_W-1:0]  q_r;
  logic [BBW-1:0]      bit_r;
  logic [AW-1:0]       addr_r;
  logic [BW-1:0]       base_r;
  logic [AW-1:0]       scan_word_r;
  logic [BW-1:0]       scan_base_r;
  logic [WB-1:0]       rdata_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [INDEX_W-1:0]  res_index_r;
  logic                res_used_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [INDEX_W-1:0]  out_index_r;
  logic                out_used_r;

  logic [PROD_W-1:0]   prod;
  logic [INDEX_W-1:0]  rem;
  logic [WB-1:0]       scan_mask;
  logic [WB-1:0]       avail;
  logic [BBW-1:0]      pos;
  logic                found;
  logic                alloc_found;
  logic                scan_last;
  logic [BW-1:0]       found_idx;
  logic                in_range;
  logic                cur_bit;
  logic                free_ok;
  logic [WB-1:0]       clr_word;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [WB-1:0]       mem_wdata;
  logic                addr_last;
  logic [STATUS_W-1:0] eval_status;
  logic [INDEX_W-1:0]  eval_index;
  logic                eval_used;

  assign prod      = PROD_W'(in_block_index) * PROD_W'(RECIP);
  assign rem       = idx_r - INDEX_W'(q_r * MAP_WORD_BITS);
  assign addr_last = (addr_r == AW'(LAST_WORD));
  assign scan_last = (scan_word_r == AW'(LAST_WORD));
  assign in_range  = (32'(idx_r) < BLOCK_COUNT);
  assign cur_bit   = in_range && rdata_r[bit_r];
  assign free_ok   = (idx_r != '0) && cur_bit;

  always_comb begin
    for (int b = 0; b < WB; b++) begin
      scan_mask[b] = 1'b1;
      if (scan_word_r == AW'(START_WORD) && b < START_BIT) begin
        scan_mask[b] = 1'b0;
      end
      if (scan_last && b >= LAST_BITS) begin
        scan_mask[b] = 1'b0;
      end
    end
  end

  assign avail = ~rdata_r & scan_mask;
  assign found = |avail;

  always_comb begin
    pos = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (avail[b]) begin
        pos = BBW'(b);
      end
    end
  end

  assign alloc_found = !ALLOC_NONE && found;
  assign found_idx   = scan_base_r + BW'(pos);

  always_comb begin
    for (int b = 0; b < WB; b++) begin
      clr_word[b] = (32'(addr_r) < FULL_WORDS) ||
                    ((32'(addr_r) == FULL_WORDS) && (b < PART_BITS));
    end
  end

  always_comb begin
    eval_status = STAT_INVALID;
    eval_index  = idx_r;
    eval_used   = 1'b0;
    unique case (req_r)
      REQ_ALLOC: begin
        if (alloc_found) begin
          eval_status = STAT_OK;
          eval_index  = INDEX_W'(found_idx);
          eval_used   = 1'b1;
        end else begin
          eval_status = STAT_FULL;
          eval_index  = '0;
        end
      end
      REQ_FREE: begin
        eval_status = free_ok ? STAT_OK : STAT_INVALID;
        eval_used   = free_ok ? 1'b0 : cur_bit;
      end
      REQ_CHECK: begin
        eval_status = in_range ? STAT_OK : STAT_INVALID;
        eval_used   = cur_bit;
      end
      default: begin
        eval_status = STAT_INVALID;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_word_r;
    mem_wdata = rdata_r;
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = addr_r;
      mem_wdata = clr_word;
    end else if (cmd.eval && req_r == REQ_ALLOC && alloc_found) begin
      mem_we    = 1'b1;
      mem_wdata = rdata_r | (WB'(1) << pos);
    end else if (cmd.eval && req_r == REQ_FREE && free_ok) begin
      mem_we    = 1'b1;
      mem_wdata = rdata_r & ~(WB'(1) << bit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    scan_word_r <= addr_r;
    scan_base_r <= base_r;
    if (cmd.load) begin
      req_r <= in_req_type;
      idx_r <= in_block_index;
      q_r   <= prod[RECIP_SH+INDEX_W-1:RECIP_SH];
    end
    if (cmd.prep) begin
      bit_r <= BBW'(rem);
    end
    if (cmd.eval && stat.eval_done) begin
      res_status_r <= eval_status;
      res_index_r  <= eval_index;
      res_used_r   <= eval_used;
    end
    if (cmd.finish) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_used_r   <= res_used_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        if (!addr_last) begin
          addr_r <= addr_r + AW'(1);
        end
      end else if (cmd.prep) begin
        if (req_r == REQ_ALLOC) begin
          addr_r <= AW'(START_WORD);
          base_r <= BW'(START_BASE);
        end else begin
          addr_r <= AW'(q_r);
        end
      end else if (cmd.run && req_r == REQ_ALLOC && !addr_last) begin
        addr_r <= addr_r + AW'(1);
        base_r <= base_r + BW'(WB);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.clear_last = addr_last;
  assign stat.eval_done  = (req_r != REQ_ALLOC) || alloc_found || ALLOC_NONE || scan_last;
  assign stat.out_free   = !out_valid_r || out_tready;

  assign out_tvalid       = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_index = out_index_r;
  assign out_used         = out_used_r;

endmodule

`default_nettype wire
